// ===== rtl/efp_pkg.sv =====
// Shared types and constants of the escape-time fractal pixel unit.
`default_nettype none

package efp_pkg;

   localparam int COORD_BITS     = 32;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MAX_ITER_BITS  = 16;
   localparam int EXP_REG_BITS   = 4;
   localparam int MAG_BITS       = 36;
   localparam int MUL_BITS       = COORD_BITS + 1;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int SQ_IN_BITS     = 2 * COORD_BITS;
   localparam int ROOT_BITS      = COORD_BITS;

   localparam logic [MAX_ITER_BITS-1:0] MAX_ITER_RESET = MAX_ITER_BITS'(255);
   localparam logic [EXP_REG_BITS-1:0]  EXPONENT_RESET = EXP_REG_BITS'(2);
   localparam logic [COORD_BITS-1:0]    RADIUS_RESET   = COORD_BITS'(536870912);

   localparam logic [SQ_IN_BITS-1:0] SQ_TOP_BIT = SQ_IN_BITS'(1) << (SQ_IN_BITS - 2);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE     = 3'd0,
      CSR_CONST    = 3'd1,
      CSR_ORIGIN   = 3'd2,
      CSR_STEP     = 3'd3,
      CSR_MAX_ITER = 3'd4,
      CSR_EXPONENT = 3'd5,
      CSR_RADIUS   = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RSQ,
      S_MAP_RE,
      S_MAP_IM,
      S_MAP_END,
      S_SQ_RE,
      S_SQ_IM,
      S_CHECK,
      S_CM0,
      S_CM1,
      S_CM2,
      S_CM3,
      S_CM4,
      S_ADD,
      S_SQRT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/efp_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none

module efp_isqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [efp_pkg::SQ_IN_BITS-1:0]  value,
   output logic                                 done,
   output logic      [efp_pkg::ROOT_BITS-1:0]   root
);

   logic                             run_ff;
   logic                             done_ff;
   logic [efp_pkg::SQ_IN_BITS-1:0]   rem_ff;
   logic [efp_pkg::SQ_IN_BITS-1:0]   rem_in;
   logic [efp_pkg::SQ_IN_BITS-1:0]   res_ff;
   logic [efp_pkg::SQ_IN_BITS-1:0]   res_in;
   logic [efp_pkg::SQ_IN_BITS-1:0]   bit_ff;
   logic [efp_pkg::SQ_IN_BITS-1:0]   trial;

   always_comb begin
      trial = res_ff + bit_ff;
      if (rem_ff >= trial) begin
         rem_in = rem_ff - trial;
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         rem_in = rem_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && bit_ff[0]) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= value;
         res_ff <= '0;
         bit_ff <= efp_pkg::SQ_TOP_BIT;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[efp_pkg::ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/escape_time_fractal_pixel_unit.sv =====
// Top level of the escape-time fractal pixel unit (Julia, Mandelbrot, multibrot).
//
//   Port group | Direction | Handshake                 | Payload
//   request    | in        | start high, busy low      | req_pixel_x, req_pixel_y
//   result     | out       | rsp_valid, one cycle      | rsp_iter_count, rsp_final_magnitude
//   csr        | in        | csr_write_en              | csr_index, csr_wdata
//
// A single 33x33 multiplier is shared by every product; each complex multiply steps
// through states S_CM0 to S_CM4, p - 1 of them per z update for effective exponent p,
// and the final square root is computed bit-serially in efp_isqrt.
// busy stays high from acceptance until the result strobe; the next request can be
// taken in the cycle the result is shown. Reset restores the register defaults and
// idles the sequencer. The receiver cannot stall the result.
`default_nettype none

module escape_time_fractal_pixel_unit #(
   parameter int FRAC_BITS    = 28,
   parameter int PIXEL_BITS   = 12,
   parameter int MAX_EXPONENT = 8,
   parameter int ITER_BITS    = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [PIXEL_BITS-1:0]                req_pixel_x,
   input  wire logic [PIXEL_BITS-1:0]                req_pixel_y,
   output logic                                      rsp_valid,
   output logic      [ITER_BITS:0]                   rsp_iter_count,
   output logic      [efp_pkg::MAG_BITS-1:0]         rsp_final_magnitude,
   input  wire logic                                 csr_write_en,
   input  wire logic [efp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [efp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CB   = efp_pkg::COORD_BITS;
   localparam int MB   = efp_pkg::MUL_BITS;
   localparam int PB   = efp_pkg::PROD_BITS;
   localparam int SB   = efp_pkg::SQ_IN_BITS;
   localparam int EXP_W = $clog2(MAX_EXPONENT + 1);
   localparam int EXP_CMP_W = efp_pkg::EXP_REG_BITS + 1;

   localparam logic signed [PB-1:0] ROUND_HALF = PB'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PB-1:0] COORD_MAX  = PB'((64'sd1 <<< (CB - 1)) - 64'sd1);
   localparam logic signed [PB-1:0] COORD_MIN  = -(PB'(1) <<< (CB - 1));

   // Configuration registers.
   logic                                   mode_ff;
   logic [efp_pkg::CSR_DATA_BITS-1:0]      const_ff;
   logic [efp_pkg::CSR_DATA_BITS-1:0]      origin_ff;
   logic [efp_pkg::CSR_DATA_BITS-1:0]      step_ff;
   logic [efp_pkg::MAX_ITER_BITS-1:0]      max_iter_ff;
   logic [efp_pkg::EXP_REG_BITS-1:0]       exponent_ff;
   logic [CB-1:0]                          radius_ff;

   efp_pkg::state_type state_ff, state_in;

   logic [PIXEL_BITS-1:0]    pix_x_ff;
   logic [PIXEL_BITS-1:0]    pix_y_ff;
   logic [SB-1:0]            r2_ff;
   logic signed [CB-1:0]     pt_re_ff;
   logic signed [CB-1:0]     z_re_ff, z_im_ff;
   logic signed [CB-1:0]     c_re_ff, c_im_ff;
   logic signed [CB-1:0]     t_re_ff, t_im_ff;
   logic signed [CB-1:0]     t_new_re_ff;
   logic signed [PB-1:0]     acc_ff;
   logic signed [PB-1:0]     prod_ff;
   logic signed [PB-1:0]     prod_in;
   logic [ITER_BITS-1:0]     updates_ff;
   logic [EXP_W-1:0]         deg_ff;

   logic                             rsp_valid_ff;
   logic [ITER_BITS:0]               rsp_iter_count_ff;
   logic [efp_pkg::MAG_BITS-1:0]     rsp_final_magnitude_ff;

   logic signed [MB-1:0]     mul_a, mul_b;
   logic signed [CB-1:0]     org_re, org_im, stp_re, stp_im, cst_re, cst_im;
   logic signed [CB-1:0]     pt_im;
   logic [SB-1:0]            mag2;
   logic [ITER_BITS-1:0]     limit;
   logic [EXP_CMP_W-1:0]     exp_wide;
   logic [EXP_W-1:0]         p_eff;
   logic [EXP_W-1:0]         deg_next;
   logic                     accept;
   logic                     finish;
   logic                     last_mul;
   logic                     sq_start;
   logic                     sq_done;
   logic [efp_pkg::ROOT_BITS-1:0] sq_root;

   function automatic logic signed [CB-1:0] sat_coord(input logic signed [PB-1:0] v);
      logic signed [CB-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[CB-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[CB-1:0];
      end else begin
         r = v[CB-1:0];
      end
      return r;
   endfunction

   // Rounds a sum or difference of two products half up to the coordinate format, then saturates.
   function automatic logic signed [CB-1:0] round_coord(input logic signed [PB-1:0] v);
      logic signed [PB-1:0] biased;
      biased = v + ROUND_HALF;
      return sat_coord(biased >>> FRAC_BITS);
   endfunction

   assign org_re = $signed(origin_ff[2*CB-1:CB]);
   assign org_im = $signed(origin_ff[CB-1:0]);
   assign stp_re = $signed(step_ff[2*CB-1:CB]);
   assign stp_im = $signed(step_ff[CB-1:0]);
   assign cst_re = $signed(const_ff[2*CB-1:CB]);
   assign cst_im = $signed(const_ff[CB-1:0]);

   assign accept   = start && !busy;
   assign limit    = ITER_BITS'(max_iter_ff);
   assign mag2     = acc_ff[SB-1:0] + prod_ff[SB-1:0];
   assign finish   = (updates_ff == limit) || (mag2 > r2_ff);
   assign deg_next = deg_ff + 1'b1;
   assign last_mul = (deg_next == p_eff);
   assign pt_im    = sat_coord(PB'(org_im) + prod_ff);

   // Exponents of zero act as one; those above the maximum act as the maximum.
   always_comb begin
      exp_wide = EXP_CMP_W'(exponent_ff);
      if (exp_wide == '0) begin
         p_eff = EXP_W'(1);
      end else if (exp_wide > EXP_CMP_W'(MAX_EXPONENT)) begin
         p_eff = EXP_W'(MAX_EXPONENT);
      end else begin
         p_eff = EXP_W'(exp_wide);
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efp_pkg::S_IDLE:    if (accept) state_in = efp_pkg::S_RSQ;
         efp_pkg::S_RSQ:     state_in = efp_pkg::S_MAP_RE;
         efp_pkg::S_MAP_RE:  state_in = efp_pkg::S_MAP_IM;
         efp_pkg::S_MAP_IM:  state_in = efp_pkg::S_MAP_END;
         efp_pkg::S_MAP_END: state_in = efp_pkg::S_SQ_RE;
         efp_pkg::S_SQ_RE:   state_in = efp_pkg::S_SQ_IM;
         efp_pkg::S_SQ_IM:   state_in = efp_pkg::S_CHECK;
         efp_pkg::S_CHECK: begin
            if (finish) begin
               state_in = efp_pkg::S_SQRT;
            end else if (p_eff == EXP_W'(1)) begin
               state_in = efp_pkg::S_ADD;
            end else begin
               state_in = efp_pkg::S_CM0;
            end
         end
         efp_pkg::S_CM0:     state_in = efp_pkg::S_CM1;
         efp_pkg::S_CM1:     state_in = efp_pkg::S_CM2;
         efp_pkg::S_CM2:     state_in = efp_pkg::S_CM3;
         efp_pkg::S_CM3:     state_in = efp_pkg::S_CM4;
         efp_pkg::S_CM4:     state_in = last_mul ? efp_pkg::S_ADD : efp_pkg::S_CM0;
         efp_pkg::S_ADD:     state_in = efp_pkg::S_SQ_RE;
         efp_pkg::S_SQRT:    if (sq_done) state_in = efp_pkg::S_IDLE;
         default:            state_in = efp_pkg::S_IDLE;
      endcase
   end

   // Multiplier operand selection and control outputs.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      sq_start = 1'b0;
      unique case (state_ff)
         efp_pkg::S_RSQ: begin
            mul_a = $signed(MB'(radius_ff));
            mul_b = $signed(MB'(radius_ff));
         end
         efp_pkg::S_MAP_RE: begin
            mul_a = $signed(MB'(pix_x_ff));
            mul_b = MB'(stp_re);
         end
         efp_pkg::S_MAP_IM: begin
            mul_a = $signed(MB'(pix_y_ff));
            mul_b = MB'(stp_im);
         end
         efp_pkg::S_SQ_RE: begin
            mul_a = MB'(z_re_ff);
            mul_b = MB'(z_re_ff);
         end
         efp_pkg::S_SQ_IM: begin
            mul_a = MB'(z_im_ff);
            mul_b = MB'(z_im_ff);
         end
         efp_pkg::S_CHECK: sq_start = finish;
         efp_pkg::S_CM0: begin
            mul_a = MB'(t_re_ff);
            mul_b = MB'(z_re_ff);
         end
         efp_pkg::S_CM1: begin
            mul_a = MB'(t_im_ff);
            mul_b = MB'(z_im_ff);
         end
         efp_pkg::S_CM2: begin
            mul_a = MB'(t_re_ff);
            mul_b = MB'(z_im_ff);
         end
         efp_pkg::S_CM3: begin
            mul_a = MB'(t_im_ff);
            mul_b = MB'(z_re_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == efp_pkg::S_SQRT) && sq_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         const_ff    <= '0;
         origin_ff   <= '0;
         step_ff     <= '0;
         max_iter_ff <= efp_pkg::MAX_ITER_RESET;
         exponent_ff <= efp_pkg::EXPONENT_RESET;
         radius_ff   <= efp_pkg::RADIUS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            efp_pkg::CSR_MODE:     mode_ff     <= csr_wdata[0];
            efp_pkg::CSR_CONST:    const_ff    <= csr_wdata;
            efp_pkg::CSR_ORIGIN:   origin_ff   <= csr_wdata;
            efp_pkg::CSR_STEP:     step_ff     <= csr_wdata;
            efp_pkg::CSR_MAX_ITER: max_iter_ff <= csr_wdata[efp_pkg::MAX_ITER_BITS-1:0];
            efp_pkg::CSR_EXPONENT: exponent_ff <= csr_wdata[efp_pkg::EXP_REG_BITS-1:0];
            efp_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // Datapath registers; the product register is the shared multiplier's output stage.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (state_ff)
         efp_pkg::S_IDLE: begin
            if (accept) begin
               pix_x_ff <= req_pixel_x;
               pix_y_ff <= req_pixel_y;
            end
         end
         efp_pkg::S_MAP_RE: r2_ff <= prod_ff[SB-1:0];
         efp_pkg::S_MAP_IM: pt_re_ff <= sat_coord(PB'(org_re) + prod_ff);
         efp_pkg::S_MAP_END: begin
            if (mode_ff) begin
               c_re_ff <= pt_re_ff;
               c_im_ff <= pt_im;
               z_re_ff <= cst_re;
               z_im_ff <= cst_im;
            end else begin
               z_re_ff <= pt_re_ff;
               z_im_ff <= pt_im;
               c_re_ff <= cst_re;
               c_im_ff <= cst_im;
            end
            updates_ff <= '0;
         end
         efp_pkg::S_SQ_IM: acc_ff <= prod_ff;
         efp_pkg::S_CHECK: begin
            t_re_ff <= z_re_ff;
            t_im_ff <= z_im_ff;
            deg_ff  <= EXP_W'(1);
         end
         efp_pkg::S_CM1: acc_ff <= prod_ff;
         efp_pkg::S_CM2: t_new_re_ff <= round_coord(acc_ff - prod_ff);
         efp_pkg::S_CM3: acc_ff <= prod_ff;
         efp_pkg::S_CM4: begin
            t_re_ff <= t_new_re_ff;
            t_im_ff <= round_coord(acc_ff + prod_ff);
            deg_ff  <= deg_next;
         end
         efp_pkg::S_ADD: begin
            z_re_ff    <= sat_coord(PB'(t_re_ff) + PB'(c_re_ff));
            z_im_ff    <= sat_coord(PB'(t_im_ff) + PB'(c_im_ff));
            updates_ff <= updates_ff + 1'b1;
         end
         efp_pkg::S_SQRT: begin
            if (sq_done) begin
               rsp_iter_count_ff      <= (ITER_BITS + 1)'(updates_ff) + 1'b1;
               rsp_final_magnitude_ff <= efp_pkg::MAG_BITS'(sq_root);
            end
         end
         default: ;
      endcase
   end

   efp_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (mag2),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign busy                = (state_ff != efp_pkg::S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iter_count      = rsp_iter_count_ff;
   assign rsp_final_magnitude = rsp_final_magnitude_ff;

endmodule

`default_nettype wire
